@@ hw/rtl/ffhp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffhp_pkg
// Types, codes and tables shared by the frame header parser modules.
// ----------------------------------------------------------------------------
package ffhp_pkg;

  localparam int unsigned RateW  = 20;
  localparam int unsigned DepthW = 6;
  localparam int unsigned BsizeW = 17;
  localparam int unsigned NumW   = 36;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STREAM_SAMPLE_RATE     = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_STREAM_BITS_PER_SAMPLE = 4'd1;

  localparam logic [RateW-1:0]  RESET_SAMPLE_RATE = 20'd44100;
  localparam logic [DepthW-1:0] RESET_BITS_PER_SAMPLE = 6'd16;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_HDR1 = 4'd1,
    PH_HDR2 = 4'd2,
    PH_HDR3 = 4'd3,
    PH_NUM0 = 4'd4,
    PH_NUMC = 4'd5,
    PH_BS8  = 4'd6,
    PH_BSH  = 4'd7,
    PH_BSL  = 4'd8,
    PH_SR8  = 4'd9,
    PH_SRH  = 4'd10,
    PH_SRL  = 4'd11,
    PH_CRC  = 4'd12
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } ffhp_in_t;

  typedef struct packed {
    logic              blocking_strategy;
    logic [BsizeW-1:0] block_size;
    logic [RateW-1:0]  sample_rate;
    logic [3:0]        channel_assignment;
    logic [DepthW-1:0] sample_size;
    logic [NumW-1:0]   frame_or_sample_number;
    logic [7:0]        header_crc;
    logic [3:0]        error_flags;
    logic [CountW-1:0] frame_index;
  } ffhp_out_t;

  // header state collected before the crc byte
  typedef struct packed {
    logic [15:0]     code_fields;
    logic [15:0]     bs_extra;
    logic [15:0]     sr_extra;
    logic [NumW-1:0] number;
    logic            utf8_bad;
  } ffhp_hdr_t;

  function automatic logic [RateW-1:0] rate_table(input logic [3:0] code);
    logic [RateW-1:0] r;
    case (code)
      4'd1:    r = 20'd88200;
      4'd2:    r = 20'd176400;
      4'd3:    r = 20'd192000;
      4'd4:    r = 20'd8000;
      4'd5:    r = 20'd16000;
      4'd6:    r = 20'd22050;
      4'd7:    r = 20'd24000;
      4'd8:    r = 20'd32000;
      4'd9:    r = 20'd44100;
      4'd10:   r = 20'd48000;
      4'd11:   r = 20'd96000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DepthW-1:0] size_table(input logic [2:0] code);
    logic [DepthW-1:0] s;
    case (code)
      3'd1:    s = 6'd8;
      3'd2:    s = 6'd12;
      3'd4:    s = 6'd16;
      3'd5:    s = 6'd20;
      3'd6:    s = 6'd24;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ffhp_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffhp_decode
// Turns the collected header codes and trailing fields into one result word.
// ----------------------------------------------------------------------------
module ffhp_decode import ffhp_pkg::*; (
  input  ffhp_hdr_t         hdr_i,
  input  logic [7:0]        crc_i,
  input  logic [RateW-1:0]  stream_rate_i,
  input  logic [DepthW-1:0] stream_depth_i,
  input  logic [CountW-1:0] frame_index_i,
  output ffhp_out_t         result_o
);

  logic [3:0]        bs_code;
  logic [3:0]        sr_code;
  logic [2:0]        ss_code;
  logic [BsizeW-1:0] bsize;
  logic [RateW-1:0]  rate;
  logic [DepthW-1:0] ssize;
  logic [3:0]        flags;
  logic [25:0]       rate_khz;
  logic [19:0]       rate_tens;

  assign bs_code = hdr_i.code_fields[14:11];
  assign sr_code = hdr_i.code_fields[10:7];
  assign ss_code = hdr_i.code_fields[2:0];

  assign rate_khz  = 26'(hdr_i.sr_extra) * 26'd1000;
  assign rate_tens = 20'(hdr_i.sr_extra) * 20'd10;

  always_comb begin
    flags = '0;
    bsize = '0;
    rate  = '0;
    ssize = '0;

    case (bs_code)
      4'd0:       flags[0] = 1'b1;
      4'd1:       bsize = 17'd192;
      4'd2, 4'd3, 4'd4, 4'd5: begin
        bsize = 17'd576 << (bs_code[1:0] - 2'd2);
      end
      4'd6, 4'd7: bsize = {1'b0, hdr_i.bs_extra} + 17'd1;
      default:    bsize = 17'd256 << bs_code[2:0];
    endcase

    case (sr_code)
      4'd0:    rate = stream_rate_i;
      4'd12:   rate = rate_khz[RateW-1:0];
      4'd13:   rate = {4'd0, hdr_i.sr_extra};
      4'd14:   rate = rate_tens;
      4'd15:   flags[1] = 1'b1;
      default: rate = rate_table(sr_code);
    endcase

    case (ss_code)
      3'd0:       ssize = stream_depth_i;
      3'd3, 3'd7: flags[2] = 1'b1;
      default:    ssize = size_table(ss_code);
    endcase

    flags[3] = hdr_i.utf8_bad;
  end

  always_comb begin
    result_o.blocking_strategy      = hdr_i.code_fields[15];
    result_o.block_size             = bsize;
    result_o.sample_rate            = rate;
    result_o.channel_assignment     = hdr_i.code_fields[6:3];
    result_o.sample_size            = ssize;
    result_o.frame_or_sample_number = hdr_i.utf8_bad ? '0 : hdr_i.number;
    result_o.header_crc             = crc_i;
    result_o.error_flags            = flags;
    result_o.frame_index            = frame_index_i;
  end

endmodule
`default_nettype wire

@@ hw/rtl/flac_frame_header_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flac_frame_header_parser
// Byte-wide audio frame header parser with one result word per header.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle, starting with a word that has frame_start
// set. Each byte is decoded in the cycle it is accepted; when the crc byte is
// taken the result word is registered and shown on the next cycle. The input
// side is stalled only when the crc byte is due and the previous result is
// still held by a stalled output; otherwise bytes flow at one per cycle.
// Sync and reserved bits are not checked and the crc is not verified.
// Configuration writes are always ready and must be made while idle.
module flac_frame_header_parser import ffhp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ffhp_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ffhp_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [RateW-1:0]   cfg_data_i
);

  phase_e            phase_q, phase_d;
  ffhp_hdr_t         hdr_q, hdr_d;
  logic [2:0]        remain_q, remain_d;
  logic [CountW-1:0] count_q, count_d;
  logic [RateW-1:0]  rate_cfg_q;
  logic [DepthW-1:0] depth_cfg_q;
  logic              out_valid_q, out_valid_d;
  ffhp_out_t         out_q;
  ffhp_out_t         result;
  logic              in_acc;
  logic              emit;
  logic [7:0]        d;
  logic [3:0]        ones;

  assign d           = in_data_i.data_byte;
  assign in_stall_o  = out_valid_q && out_stall_i && (phase_q == PH_CRC);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign emit        = in_acc && !in_data_i.frame_start && (phase_q == PH_CRC);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic phase_e after_bs(input logic [3:0] sr);
    phase_e p;
    case (sr)
      4'd12:        p = PH_SR8;
      4'd13, 4'd14: p = PH_SRH;
      default:      p = PH_CRC;
    endcase
    return p;
  endfunction

  function automatic phase_e after_number(input logic [15:0] codes);
    phase_e p;
    case (codes[14:11])
      4'd6:    p = PH_BS8;
      4'd7:    p = PH_BSH;
      default: p = after_bs(codes[10:7]);
    endcase
    return p;
  endfunction

  // leading ones of the first number byte
  always_comb begin
    casez (d)
      8'b0???????: ones = 4'd0;
      8'b10??????: ones = 4'd1;
      8'b110?????: ones = 4'd2;
      8'b1110????: ones = 4'd3;
      8'b11110???: ones = 4'd4;
      8'b111110??: ones = 4'd5;
      8'b1111110?: ones = 4'd6;
      8'b11111110: ones = 4'd7;
      default:     ones = 4'd8;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    remain_d = remain_q;
    if (in_acc) begin
      if (in_data_i.frame_start) begin
        hdr_d    = '0;
        remain_d = '0;
        phase_d  = PH_HDR1;
      end else begin
        case (phase_q)
          PH_HDR1: begin
            hdr_d.code_fields[15] = d[0];
            phase_d = PH_HDR2;
          end
          PH_HDR2: begin
            hdr_d.code_fields[14:7] = d;
            phase_d = PH_HDR3;
          end
          PH_HDR3: begin
            hdr_d.code_fields[6:3] = d[7:4];
            hdr_d.code_fields[2:0] = d[3:1];
            phase_d = PH_NUM0;
          end
          PH_NUM0: begin
            if (ones == 4'd0) begin
              hdr_d.number = NumW'(d[6:0]);
              remain_d = '0;
              phase_d  = after_number(hdr_q.code_fields);
            end else if (ones == 4'd1 || ones == 4'd8) begin
              hdr_d.utf8_bad = 1'b1;
              hdr_d.number   = '0;
              remain_d = '0;
              phase_d  = after_number(hdr_q.code_fields);
            end else begin
              hdr_d.number = (ones >= 4'd7) ? '0 : NumW'(d & (8'h7f >> ones));
              remain_d = 3'(ones - 4'd1);
              phase_d  = PH_NUMC;
            end
          end
          PH_NUMC: begin
            if (d[7:6] != 2'b10) begin
              hdr_d.utf8_bad = 1'b1;
            end
            hdr_d.number = {hdr_q.number[NumW-7:0], d[5:0]};
            remain_d = remain_q - 3'd1;
            if (remain_q == 3'd1) begin
              phase_d = after_number(hdr_q.code_fields);
            end
          end
          PH_BS8: begin
            hdr_d.bs_extra = {8'd0, d};
            phase_d = after_bs(hdr_q.code_fields[10:7]);
          end
          PH_BSH: begin
            hdr_d.bs_extra = {d, 8'd0};
            phase_d = PH_BSL;
          end
          PH_BSL: begin
            hdr_d.bs_extra[7:0] = d;
            phase_d = after_bs(hdr_q.code_fields[10:7]);
          end
          PH_SR8: begin
            hdr_d.sr_extra = {8'd0, d};
            phase_d = PH_CRC;
          end
          PH_SRH: begin
            hdr_d.sr_extra = {d, 8'd0};
            phase_d = PH_SRL;
          end
          PH_SRL: begin
            hdr_d.sr_extra[7:0] = d;
            phase_d = PH_CRC;
          end
          PH_CRC:  phase_d = PH_IDLE;
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    count_d     = emit ? count_q + 32'd1 : count_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  ffhp_decode u_decode (
    .hdr_i          (hdr_q),
    .crc_i          (d),
    .stream_rate_i  (rate_cfg_q),
    .stream_depth_i (depth_cfg_q),
    .frame_index_i  (count_q + 32'd1),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      hdr_q       <= '0;
      remain_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rate_cfg_q  <= RESET_SAMPLE_RATE;
      depth_cfg_q <= RESET_BITS_PER_SAMPLE;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      remain_q    <= remain_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_STREAM_SAMPLE_RATE) begin
          rate_cfg_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_STREAM_BITS_PER_SAMPLE) begin
          depth_cfg_q <= cfg_data_i[DepthW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= result;
    end
  end

  // crc byte taken gives a result word next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result not shown after crc byte");

  // input is only held off by a stalled pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without pending result");

  // frame start always restarts the header
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.frame_start) |=> (phase_q == PH_HDR1))
    else $error("frame start did not restart header");

  // frame count advances by one per result
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (count_q == $past(count_q) + 32'd1))
    else $error("frame count did not advance");

  // no result word is overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("pending result overwritten");

endmodule
`default_nettype wire
